// ===== rtl/tlf_pkg.sv =====
package tlf_pkg;

  localparam int unsigned STORE_DEPTH = 60;
  localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);
  localparam int unsigned CNT_W       = 6;
  localparam int unsigned COL_W       = 6;
  localparam int unsigned TAB_W       = 5;
  localparam int unsigned STEP_W      = 3;

  localparam logic [COL_W:0]  LINE_WIDTH = 7'd60;
  localparam logic [STEP_W-1:0] DIV_STEPS = 3'd6;
  localparam logic [TAB_W-1:0] TAB_RESET = 5'd8;

  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_NEWLINE = 8'h0a;

  typedef struct packed {
    logic [7:0] in_char;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last_of_run;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_DIV,
    ST_PRE_NL,
    ST_FLUSH_RD,
    ST_FLUSH_EMIT,
    ST_MID,
    ST_POST_NL,
    ST_COMMIT
  } state_e;

  typedef enum logic [1:0] {
    SEL_NEWLINE,
    SEL_CHAR,
    SEL_STORE
  } sel_e;

  typedef struct packed {
    logic load;
    logic decode;
    logic store;
    logic div_step;
    logic rd_en;
    logic emit;
    sel_e sel;
    logic last;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic is_eoi;
    logic ovf;
    logic is_blank;
    logic is_tab;
    logic is_nl;
    logic fit;
    logic w_zero;
    logic w_full;
    logic col_zero;
    logic div_done;
    logic wrap;
    logic rd_last;
    logic can_load;
  } status_t;

endpackage

// ===== rtl/tlf_ram.sv =====
module tlf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 60
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/tlf_datapath.sv =====
module tlf_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  tlf_pkg::in_item_t            in_data_i,
  input  logic                         cfg_valid_i,
  input  logic [tlf_pkg::TAB_W-1:0]    cfg_data_i,
  input  logic                         out_stall_i,
  output logic                         out_valid_o,
  output tlf_pkg::out_item_t           out_data_o,
  input  tlf_pkg::cmd_t                cmd_i,
  output tlf_pkg::status_t             status_o
);

  logic [7:0]                   char_q;
  logic                         eoi_q;
  logic [tlf_pkg::CNT_W-1:0]    w_q, w_d;
  logic [tlf_pkg::COL_W-1:0]    col_q, col_d;
  logic                         ovf_q, ovf_d;
  logic [tlf_pkg::TAB_W-1:0]    tab_q;
  logic [tlf_pkg::CNT_W-1:0]    rd_idx_q;
  logic [tlf_pkg::COL_W-1:0]    dvd_q;
  logic [tlf_pkg::TAB_W-1:0]    rem_q;
  logic [tlf_pkg::STEP_W-1:0]   step_q;
  logic                         out_valid_q;
  tlf_pkg::out_item_t           out_q;

  logic [7:0]                   ram_rdata;
  logic                         is_blank, is_tab, is_nl, term;
  logic [tlf_pkg::COL_W:0]      sum;
  logic                         fit;
  logic [tlf_pkg::COL_W-1:0]    col_base;
  logic [tlf_pkg::TAB_W-1:0]    tw_eff;
  logic [tlf_pkg::TAB_W:0]      trial;
  logic [tlf_pkg::TAB_W-1:0]    rem_next;
  logic [tlf_pkg::COL_W:0]      newcol;
  logic                         wrap;
  logic                         can_load;
  logic [7:0]                   emit_char;

  tlf_ram #(
    .WIDTH (8),
    .DEPTH (tlf_pkg::STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.store),
    .waddr_i (w_q[tlf_pkg::ADDR_W-1:0]),
    .wdata_i (char_q),
    .re_i    (cmd_i.rd_en),
    .raddr_i (rd_idx_q[tlf_pkg::ADDR_W-1:0]),
    .rdata_o (ram_rdata)
  );

  assign is_blank = !eoi_q && (char_q == tlf_pkg::CH_SPACE || char_q == tlf_pkg::CH_TAB);
  assign is_tab   = !eoi_q && (char_q == tlf_pkg::CH_TAB);
  assign is_nl    = !eoi_q && (char_q == tlf_pkg::CH_NEWLINE);
  assign term     = is_blank || is_nl;

  assign sum      = {1'b0, col_q} + {1'b0, w_q};
  assign fit      = sum < tlf_pkg::LINE_WIDTH;
  assign col_base = fit ? sum[tlf_pkg::COL_W-1:0] : w_q;
  assign tw_eff   = (tab_q == '0) ? tlf_pkg::TAB_W'(1) : tab_q;

  // one remainder bit per step
  assign trial    = {rem_q, dvd_q[tlf_pkg::COL_W-1]};
  assign rem_next = (trial >= {1'b0, tw_eff}) ? tlf_pkg::TAB_W'(trial - {1'b0, tw_eff})
                                              : trial[tlf_pkg::TAB_W-1:0];

  always_comb begin
    if (is_tab) begin
      newcol = {1'b0, col_base} + {2'b0, tw_eff} - {2'b0, rem_q};
    end else begin
      newcol = {1'b0, col_base} + (tlf_pkg::COL_W+1)'(1);
    end
  end
  assign wrap = newcol >= tlf_pkg::LINE_WIDTH;

  assign can_load = !out_valid_q || !out_stall_i;

  always_comb begin
    unique case (cmd_i.sel)
      tlf_pkg::SEL_NEWLINE: emit_char = tlf_pkg::CH_NEWLINE;
      tlf_pkg::SEL_CHAR:    emit_char = char_q;
      tlf_pkg::SEL_STORE:   emit_char = ram_rdata;
      default:              emit_char = tlf_pkg::CH_NEWLINE;
    endcase
  end

  always_comb begin
    w_d   = w_q;
    col_d = col_q;
    ovf_d = ovf_q;
    if (cmd_i.store) begin
      w_d = w_q + tlf_pkg::CNT_W'(1);
    end else if (cmd_i.commit) begin
      priority if (eoi_q) begin
        w_d   = '0;
        col_d = '0;
        ovf_d = 1'b0;
      end else if (ovf_q) begin
        if (term) begin
          w_d   = '0;
          col_d = '0;
          ovf_d = 1'b0;
        end
      end else if (is_blank) begin
        w_d   = '0;
        col_d = wrap ? '0 : newcol[tlf_pkg::COL_W-1:0];
      end else if (is_nl) begin
        w_d   = '0;
        col_d = '0;
      end else begin
        w_d   = '0;
        col_d = '0;
        ovf_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q         <= '0;
      col_q       <= '0;
      ovf_q       <= 1'b0;
      tab_q       <= tlf_pkg::TAB_RESET;
      rd_idx_q    <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      w_q   <= w_d;
      col_q <= col_d;
      ovf_q <= ovf_d;
      if (cfg_valid_i) begin
        tab_q <= cfg_data_i;
      end
      if (cmd_i.decode) begin
        rd_idx_q <= '0;
        step_q   <= '0;
      end else begin
        if (cmd_i.rd_en) begin
          rd_idx_q <= rd_idx_q + tlf_pkg::CNT_W'(1);
        end
        if (cmd_i.div_step) begin
          step_q <= step_q + tlf_pkg::STEP_W'(1);
        end
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      char_q <= in_data_i.in_char;
      eoi_q  <= in_data_i.end_of_input;
    end
    if (cmd_i.decode) begin
      dvd_q <= col_base;
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      dvd_q <= {dvd_q[tlf_pkg::COL_W-2:0], 1'b0};
      rem_q <= rem_next;
    end
    if (cmd_i.emit) begin
      out_q.out_char    <= emit_char;
      out_q.last_of_run <= cmd_i.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign status_o.is_eoi   = eoi_q;
  assign status_o.ovf      = ovf_q;
  assign status_o.is_blank = is_blank;
  assign status_o.is_tab   = is_tab;
  assign status_o.is_nl    = is_nl;
  assign status_o.fit      = fit;
  assign status_o.w_zero   = (w_q == '0);
  assign status_o.w_full   = ({1'b0, w_q} == tlf_pkg::LINE_WIDTH);
  assign status_o.col_zero = (col_q == '0);
  assign status_o.div_done = (step_q == tlf_pkg::DIV_STEPS);
  assign status_o.wrap     = wrap;
  assign status_o.rd_last  = (rd_idx_q == w_q);
  assign status_o.can_load = can_load;

endmodule

// ===== rtl/tlf_ctrl.sv =====
module tlf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  tlf_pkg::status_t  status_i,
  output tlf_pkg::cmd_t     cmd_o
);

  tlf_pkg::state_e state_q, state_d;

  logic pre_needed;
  logic post_needed;
  logic mid_nl;
  tlf_pkg::state_e after_plan;

  assign pre_needed  = (status_i.is_blank || status_i.is_nl) ? !status_i.fit
                                                              : !status_i.col_zero;
  assign post_needed = !status_i.ovf && status_i.is_blank && status_i.wrap;
  assign mid_nl      = status_i.is_eoi || status_i.is_nl
                       || (status_i.ovf && status_i.is_blank);

  always_comb begin
    if (pre_needed) begin
      after_plan = tlf_pkg::ST_PRE_NL;
    end else if (!status_i.w_zero) begin
      after_plan = tlf_pkg::ST_FLUSH_RD;
    end else begin
      after_plan = tlf_pkg::ST_MID;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tlf_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = tlf_pkg::ST_DECODE;
        end
      end
      tlf_pkg::ST_DECODE: begin
        priority if (status_i.is_eoi) begin
          state_d = status_i.ovf ? tlf_pkg::ST_MID : tlf_pkg::ST_COMMIT;
        end else if (status_i.ovf) begin
          state_d = tlf_pkg::ST_MID;
        end else if (status_i.is_tab) begin
          state_d = tlf_pkg::ST_DIV;
        end else if (status_i.is_blank || status_i.is_nl || status_i.w_full) begin
          state_d = after_plan;
        end else begin
          state_d = tlf_pkg::ST_IDLE;
        end
      end
      tlf_pkg::ST_DIV: begin
        if (status_i.div_done) begin
          state_d = after_plan;
        end
      end
      tlf_pkg::ST_PRE_NL: begin
        if (status_i.can_load) begin
          state_d = status_i.w_zero ? tlf_pkg::ST_MID : tlf_pkg::ST_FLUSH_RD;
        end
      end
      tlf_pkg::ST_FLUSH_RD: begin
        state_d = tlf_pkg::ST_FLUSH_EMIT;
      end
      tlf_pkg::ST_FLUSH_EMIT: begin
        if (status_i.can_load && status_i.rd_last) begin
          state_d = tlf_pkg::ST_MID;
        end
      end
      tlf_pkg::ST_MID: begin
        if (status_i.can_load) begin
          state_d = post_needed ? tlf_pkg::ST_POST_NL : tlf_pkg::ST_COMMIT;
        end
      end
      tlf_pkg::ST_POST_NL: begin
        if (status_i.can_load) begin
          state_d = tlf_pkg::ST_COMMIT;
        end
      end
      tlf_pkg::ST_COMMIT: begin
        state_d = tlf_pkg::ST_IDLE;
      end
      default: begin
        state_d = tlf_pkg::ST_IDLE;
      end
    endcase
  end

  // commands
  always_comb begin
    cmd_o      = '0;
    cmd_o.sel  = tlf_pkg::SEL_NEWLINE;
    in_stall_o = 1'b1;
    unique case (state_q)
      tlf_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      tlf_pkg::ST_DECODE: begin
        cmd_o.decode = 1'b1;
        cmd_o.store  = !status_i.is_eoi && !status_i.ovf && !status_i.is_blank
                       && !status_i.is_nl && !status_i.w_full;
      end
      tlf_pkg::ST_DIV: begin
        cmd_o.div_step = !status_i.div_done;
      end
      tlf_pkg::ST_PRE_NL: begin
        cmd_o.emit = status_i.can_load;
        cmd_o.sel  = tlf_pkg::SEL_NEWLINE;
      end
      tlf_pkg::ST_FLUSH_RD: begin
        cmd_o.rd_en = 1'b1;
      end
      tlf_pkg::ST_FLUSH_EMIT: begin
        cmd_o.emit  = status_i.can_load;
        cmd_o.sel   = tlf_pkg::SEL_STORE;
        cmd_o.rd_en = status_i.can_load && !status_i.rd_last;
      end
      tlf_pkg::ST_MID: begin
        cmd_o.emit = status_i.can_load;
        cmd_o.sel  = mid_nl ? tlf_pkg::SEL_NEWLINE : tlf_pkg::SEL_CHAR;
        cmd_o.last = !post_needed;
      end
      tlf_pkg::ST_POST_NL: begin
        cmd_o.emit = status_i.can_load;
        cmd_o.sel  = tlf_pkg::SEL_NEWLINE;
        cmd_o.last = 1'b1;
      end
      tlf_pkg::ST_COMMIT: begin
        cmd_o.commit = 1'b1;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tlf_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/text_line_folder.sv =====
// Word-wrapping line folder. Characters come in one per item and go out one per item,
// folded at 60 columns between words; tab stops follow the tab_width register (0 acts
// as 1). A word character may be only buffered, giving no result. A held word is read
// back from the 60-entry word store at one character per cycle while the output is not
// stalled; a tab runs a bit-serial remainder that finds the next tab stop. The result
// register lets the last result of an item wait while the next item is taken.
module text_line_folder (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  tlf_pkg::in_item_t         in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output tlf_pkg::out_item_t        out_data_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [tlf_pkg::TAB_W-1:0] cfg_data_i
);

  tlf_pkg::cmd_t    cmd;
  tlf_pkg::status_t status;

  assign cfg_ready_o = 1'b1;

  tlf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  tlf_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule
